[hw/rtl/cudc_pkg.sv]
// Shared types, constants and calendar helpers for the calendar up/down counter.
// No dependencies; imported by cudc_next, calendar_up_down_counter and the testbench.
package cudc_pkg;

  // Date/time held by the counter
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  // Command codes
  localparam logic [1:0] CMD_UP   = 2'd0;
  localparam logic [1:0] CMD_DOWN = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;

  // Unit codes
  localparam logic [2:0] UNIT_SEC   = 3'd0;
  localparam logic [2:0] UNIT_MIN   = 3'd1;
  localparam logic [2:0] UNIT_HOUR  = 3'd2;
  localparam logic [2:0] UNIT_DAY   = 3'd3;
  localparam logic [2:0] UNIT_MONTH = 3'd4;
  localparam logic [2:0] UNIT_YEAR  = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_PRESET_YEAR   = 3'd0;
  localparam logic [2:0] REG_PRESET_MONTH  = 3'd1;
  localparam logic [2:0] REG_PRESET_DAY    = 3'd2;
  localparam logic [2:0] REG_PRESET_HOUR   = 3'd3;
  localparam logic [2:0] REG_PRESET_MINUTE = 3'd4;
  localparam logic [2:0] REG_PRESET_SECOND = 3'd5;

  localparam int unsigned CFG_DATA_W = 14;

  // Field limits
  localparam logic [13:0] YEAR_MIN  = 14'd1000;
  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [3:0]  MONTH_MAX = 4'd12;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [4:0]  DAY_MAX   = 5'd31;
  localparam logic [4:0]  HOUR_MAX  = 5'd23;
  localparam logic [5:0]  MINSEC_MAX = 6'd59;

  // Reset value of both the state and the presets
  localparam cal_t CAL_RESET = '{year: 14'd2020, month: 4'd12, day: 5'd31,
                                 hour: 5'd13, minute: 6'd45, second: 6'd32};

  // Divisibility by 25 on 14 bits: multiply by the inverse of 25 mod 2^14
  // and compare against floor((2^14-1)/25).
  localparam logic [13:0] INV25_14 = 14'd7209;
  localparam logic [13:0] DIV25_LIM = 14'd655;

  // Gregorian leap test: div by 4 and (not by 100, or by 400)
  function automatic logic is_leap(input logic [13:0] y);
    logic [13:0] prod;
    logic        div25;
    prod  = y * INV25_14;
    div25 = (prod <= DIV25_LIM);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  // Days in a month
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[hw/rtl/cudc_next.sv]
// Next-state logic of the calendar counter: step up/down with carry and borrow,
// preset load with field checks, day clamp. Depends on cudc_pkg.
module cudc_next (
  input  logic [1:0]     cmd_i,
  input  logic [2:0]     unit_i,
  input  cudc_pkg::cal_t cur_i,
  input  cudc_pkg::cal_t preset_i,
  output cudc_pkg::cal_t nxt_o,
  output logic           err_o
);
  import cudc_pkg::*;

  logic       leap_cur, leap_new;
  logic [4:0] len_cur, len_new;
  logic       s_max, m_max, h_max, d_max, mo_max;
  logic       s_zero, m_zero, h_zero;
  logic       up_min, up_hr, up_day, up_mon, up_yr;
  logic       dn_min, dn_hr, dn_day, dn_mon, dn_yr;
  logic       step_fail, ld_year_ok, ld_month_ok, ld_day_ok;
  logic       ld_hour_ok, ld_min_ok, ld_sec_ok;
  cal_t       cand;
  cal_t       fin;

  // Length of the current month, for day carry
  assign leap_cur = is_leap(cur_i.year);
  assign len_cur  = month_len(cur_i.month, leap_cur);

  // Rollover / underflow flags
  assign s_max  = (cur_i.second == MINSEC_MAX);
  assign m_max  = (cur_i.minute == MINSEC_MAX);
  assign h_max  = (cur_i.hour == HOUR_MAX);
  assign d_max  = (cur_i.day >= len_cur);
  assign mo_max = (cur_i.month >= MONTH_MAX);
  assign s_zero = (cur_i.second == 6'd0);
  assign m_zero = (cur_i.minute == 6'd0);
  assign h_zero = (cur_i.hour == 5'd0);

  // Carry chain
  assign up_min = (unit_i == UNIT_MIN)   || ((unit_i == UNIT_SEC) && s_max);
  assign up_hr  = (unit_i == UNIT_HOUR)  || (up_min && m_max);
  assign up_day = (unit_i == UNIT_DAY)   || (up_hr && h_max);
  assign up_mon = (unit_i == UNIT_MONTH) || (up_day && d_max);
  assign up_yr  = (unit_i == UNIT_YEAR)  || (up_mon && mo_max);

  // Borrow chain
  assign dn_min = (unit_i == UNIT_MIN)   || ((unit_i == UNIT_SEC) && s_zero);
  assign dn_hr  = (unit_i == UNIT_HOUR)  || (dn_min && m_zero);
  assign dn_day = (unit_i == UNIT_DAY)   || (dn_hr && h_zero);
  assign dn_mon = (unit_i == UNIT_MONTH) || (dn_day && (cur_i.day <= 5'd1));
  assign dn_yr  = (unit_i == UNIT_YEAR)  || (dn_mon && (cur_i.month <= 4'd1));

  // Preset checks
  assign ld_year_ok  = (preset_i.year >= YEAR_MIN) && (preset_i.year <= YEAR_MAX);
  assign ld_month_ok = (preset_i.month >= 4'd1) && (preset_i.month <= MONTH_MAX);
  assign ld_hour_ok  = (preset_i.hour <= HOUR_MAX);
  assign ld_min_ok   = (preset_i.minute <= MINSEC_MAX);
  assign ld_sec_ok   = (preset_i.second <= MINSEC_MAX);

  // Candidate date before the day clamp
  always_comb begin
    cand      = cur_i;
    step_fail = 1'b0;
    case (cmd_i)
      CMD_UP: begin
        if (unit_i == UNIT_SEC) cand.second = s_max ? 6'd0 : cur_i.second + 6'd1;
        if (up_min) cand.minute = m_max ? 6'd0 : cur_i.minute + 6'd1;
        if (up_hr)  cand.hour   = h_max ? 5'd0 : cur_i.hour + 5'd1;
        if (up_day) cand.day    = d_max ? 5'd1 : cur_i.day + 5'd1;
        if (up_mon) cand.month  = mo_max ? 4'd1 : cur_i.month + 4'd1;
        if (up_yr) begin
          cand.year = cur_i.year + 14'd1;
          step_fail = (cur_i.year >= YEAR_MAX);
        end
      end
      CMD_DOWN: begin
        if (unit_i == UNIT_SEC) cand.second = s_zero ? MINSEC_MAX : cur_i.second - 6'd1;
        if (dn_min) cand.minute = m_zero ? MINSEC_MAX : cur_i.minute - 6'd1;
        if (dn_hr)  cand.hour   = h_zero ? HOUR_MAX : cur_i.hour - 5'd1;
        // borrowing past day 1 lands on 31; the clamp below trims it
        if (dn_day) cand.day    = (cur_i.day <= 5'd1) ? DAY_MAX : cur_i.day - 5'd1;
        if (dn_mon) cand.month  = (cur_i.month <= 4'd1) ? MONTH_MAX : cur_i.month - 4'd1;
        if (dn_yr) begin
          cand.year = cur_i.year - 14'd1;
          step_fail = (cur_i.year <= YEAR_MIN);
        end
      end
      CMD_LOAD: begin
        if (ld_year_ok)  cand.year  = preset_i.year;
        if (ld_month_ok) cand.month = preset_i.month;
        if (ld_hour_ok)  cand.hour   = preset_i.hour;
        if (ld_min_ok)   cand.minute = preset_i.minute;
        if (ld_sec_ok)   cand.second = preset_i.second;
      end
      default: begin
        cand = cur_i;
      end
    endcase
  end

  // Length of the month the result lands in
  assign leap_new  = is_leap(cand.year);
  assign len_new   = month_len(cand.month, leap_new);
  assign ld_day_ok = (preset_i.day >= 5'd1) && (preset_i.day <= len_new);

  // Day clamp, preset day, refusal at the year limits
  always_comb begin
    fin = cand;
    if (cand.day > len_new) fin.day = len_new;
    err_o = 1'b0;
    if (cmd_i == CMD_LOAD) begin
      if (ld_day_ok) fin.day = preset_i.day;
      err_o = !(ld_year_ok && ld_month_ok && ld_day_ok && ld_hour_ok &&
                ld_min_ok && ld_sec_ok);
    end
    nxt_o = fin;
    if (step_fail) begin
      nxt_o = cur_i;
      err_o = 1'b1;
    end
  end

endmodule

[hw/rtl/calendar_up_down_counter.sv]
// Top level of the calendar up/down counter: input register, date/time state,
// preset registers and result handshake. Depends on cudc_pkg and cudc_next.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+-------------------------------
//   in      | input     | in_valid_i / in_ready_o    | command_i, unit_i
//   out     | output    | out_valid_o / out_ready_i  | year..second_out_o, error_flag_o
//   cfg     | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// One beat per cycle sustained while out_ready_i stays high. A beat is held in the input
// register until the result slot is free; then the next-state logic updates the state,
// which is the result, and out_valid_o is raised.
// A stalled result holds the state; the input register still takes one beat.
// Reset loads the date 2020-12-31 13:45:32 into both state and presets.
module calendar_up_down_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_idx_i,
  input  logic [cudc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        command_i,
  input  logic [2:0]                        unit_i,
  // results
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [13:0]                       year_out_o,
  output logic [3:0]                        month_out_o,
  output logic [4:0]                        day_out_o,
  output logic [4:0]                        hour_out_o,
  output logic [5:0]                        minute_out_o,
  output logic [5:0]                        second_out_o,
  output logic                              error_flag_o
);
  import cudc_pkg::*;

  cal_t       preset_q;
  cal_t       cur_q, cur_d;
  logic       in_vld_q;
  logic [1:0] cmd_q;
  logic [2:0] unit_q;
  logic       out_vld_q;
  logic       err_q, err_d;
  logic       advance;

  // Preset registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q <= CAL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PRESET_YEAR:   preset_q.year   <= cfg_wdata_i[13:0];
        REG_PRESET_MONTH:  preset_q.month  <= cfg_wdata_i[3:0];
        REG_PRESET_DAY:    preset_q.day    <= cfg_wdata_i[4:0];
        REG_PRESET_HOUR:   preset_q.hour   <= cfg_wdata_i[4:0];
        REG_PRESET_MINUTE: preset_q.minute <= cfg_wdata_i[5:0];
        REG_PRESET_SECOND: preset_q.second <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // Beat moves from input register to state when the result slot is free
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= command_i;
      unit_q <= unit_i;
    end
  end

  // Next-state logic
  cudc_next u_next (
    .cmd_i    (cmd_q),
    .unit_i   (unit_q),
    .cur_i    (cur_q),
    .preset_i (preset_q),
    .nxt_o    (cur_d),
    .err_o    (err_d)
  );

  // State; it also serves as the result payload, held while the result stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= CAL_RESET;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) cur_q <= cur_d;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) err_q <= err_d;
  end

  // Result ports
  assign out_valid_o  = out_vld_q;
  assign year_out_o   = cur_q.year;
  assign month_out_o  = cur_q.month;
  assign day_out_o    = cur_q.day;
  assign hour_out_o   = cur_q.hour;
  assign minute_out_o = cur_q.minute;
  assign second_out_o = cur_q.second;
  assign error_flag_o = err_q;

endmodule

[tb/sv/calendar_up_down_counter_tb.sv]
// Self-checking testbench for calendar_up_down_counter: drives step and load commands,
// predicts each date/time result and compares it beat by beat with the block's output.
// Depends on cudc_pkg and the calendar_up_down_counter RTL.
`timescale 1ns / 100ps

module calendar_up_down_counter_tb;
  import cudc_pkg::*;

  localparam int unsigned NUM_PHASES     = 10;
  localparam int unsigned PHASE_LEN      = 190;
  localparam int unsigned LONG_HOLD      = 250;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;

  // command and unit codes the block treats as no-ops
  localparam logic [1:0] CMD_SPARE     = 2'd3;
  localparam logic [2:0] UNIT_SPARE_LO = 3'd6;
  localparam logic [2:0] UNIT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] unit;
  } order_t;

  typedef struct packed {
    cal_t date;
    logic err;
  } reading_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [2:0]            cfg_idx_i = REG_PRESET_YEAR;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            command_i = CMD_UP;
  logic [2:0]            unit_i = UNIT_SEC;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [13:0]           year_out_o;
  logic [3:0]            month_out_o;
  logic [4:0]            day_out_o;
  logic [4:0]            hour_out_o;
  logic [5:0]            minute_out_o;
  logic [5:0]            second_out_o;
  logic                  error_flag_o;

  calendar_up_down_counter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .unit_i       (unit_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .year_out_o   (year_out_o),
    .month_out_o  (month_out_o),
    .day_out_o    (day_out_o),
    .hour_out_o   (hour_out_o),
    .minute_out_o (minute_out_o),
    .second_out_o (second_out_o),
    .error_flag_o (error_flag_o)
  );

  always #4 clk_i = ~clk_i;

  // shadow copy of the counter and its preset registers
  cal_t     shadow_date;
  cal_t     load_regs;
  order_t   pending_orders[$];
  reading_t expected_readings[$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned n_steps      = 0;
  int unsigned n_loads      = 0;
  int unsigned n_flagged    = 0;
  int unsigned n_settings   = 0;
  int unsigned idle_cycles  = 0;

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // keep the day inside the month after a month or year change
  function automatic void trim_day(inout cal_t d);
    int unsigned len;
    len = days_in_month(d.month, d.year);
    if (d.day > len) d.day = 5'(len);
  endfunction

  // one unit up with carry; 0 when the year would pass its top
  function automatic bit tick_forward(inout cal_t d, input logic [2:0] u);
    if (u > UNIT_YEAR) return 1'b1;
    if (u == UNIT_SEC) begin
      if (d.second < MINSEC_MAX) begin
        d.second = d.second + 6'd1;
        return 1'b1;
      end
      d.second = '0;
    end
    if (u <= UNIT_MIN) begin
      if (d.minute < MINSEC_MAX) begin
        d.minute = d.minute + 6'd1;
        return 1'b1;
      end
      d.minute = '0;
    end
    if (u <= UNIT_HOUR) begin
      if (d.hour < HOUR_MAX) begin
        d.hour = d.hour + 5'd1;
        return 1'b1;
      end
      d.hour = '0;
    end
    if (u <= UNIT_DAY) begin
      if (d.day < days_in_month(d.month, d.year)) begin
        d.day = d.day + 5'd1;
        return 1'b1;
      end
      d.day = 5'd1;
    end
    if (u <= UNIT_MONTH) begin
      if (d.month < MONTH_MAX) begin
        d.month = d.month + 4'd1;
        trim_day(d);
        return 1'b1;
      end
      d.month = 4'd1;
    end
    if (d.year >= YEAR_MAX) return 1'b0;
    d.year = d.year + 14'd1;
    trim_day(d);
    return 1'b1;
  endfunction

  // one unit down with borrow; 0 when the year would drop below its floor
  function automatic bit tick_back(inout cal_t d, input logic [2:0] u);
    if (u > UNIT_YEAR) return 1'b1;
    if (u == UNIT_YEAR) begin
      if (d.year <= YEAR_MIN) return 1'b0;
      d.year = d.year - 14'd1;
      trim_day(d);
      return 1'b1;
    end
    if (u == UNIT_MONTH) begin
      if (d.month > 4'd1) begin
        d.month = d.month - 4'd1;
        trim_day(d);
        return 1'b1;
      end
      if (d.year <= YEAR_MIN) return 1'b0;
      d.year  = d.year - 14'd1;
      d.month = MONTH_MAX;
      trim_day(d);
      return 1'b1;
    end
    if (u == UNIT_SEC) begin
      if (d.second > 6'd0) begin
        d.second = d.second - 6'd1;
        return 1'b1;
      end
      d.second = MINSEC_MAX;
    end
    if (u <= UNIT_MIN) begin
      if (d.minute > 6'd0) begin
        d.minute = d.minute - 6'd1;
        return 1'b1;
      end
      d.minute = MINSEC_MAX;
    end
    if (u <= UNIT_HOUR) begin
      if (d.hour > 5'd0) begin
        d.hour = d.hour - 5'd1;
        return 1'b1;
      end
      d.hour = HOUR_MAX;
    end
    // day borrow: previous month takes its own last day
    if (d.day > 5'd1) begin
      d.day = d.day - 5'd1;
      return 1'b1;
    end
    if (d.month > 4'd1) begin
      d.month = d.month - 4'd1;
      d.day   = 5'(days_in_month(d.month, d.year));
      return 1'b1;
    end
    if (d.year <= YEAR_MIN) return 1'b0;
    d.year  = d.year - 14'd1;
    d.month = MONTH_MAX;
    d.day   = DAY_MAX;
    return 1'b1;
  endfunction

  // load presets field by field; a bad field is skipped and flags an error
  function automatic bit take_presets(inout cal_t d);
    bit bad;
    bad = 1'b0;
    if (load_regs.year >= YEAR_MIN && load_regs.year <= YEAR_MAX) d.year = load_regs.year;
    else bad = 1'b1;
    if (load_regs.month >= 4'd1 && load_regs.month <= MONTH_MAX) d.month = load_regs.month;
    else bad = 1'b1;
    if (load_regs.day >= 5'd1 && load_regs.day <= days_in_month(d.month, d.year)) begin
      d.day = load_regs.day;
    end else begin
      bad = 1'b1;
      trim_day(d);
    end
    if (load_regs.hour <= HOUR_MAX) d.hour = load_regs.hour;
    else bad = 1'b1;
    if (load_regs.minute <= MINSEC_MAX) d.minute = load_regs.minute;
    else bad = 1'b1;
    if (load_regs.second <= MINSEC_MAX) d.second = load_regs.second;
    else bad = 1'b1;
    return bad;
  endfunction

  // apply one command to the shadow date and return the expected result
  function automatic reading_t apply_command(input logic [1:0] cmd, input logic [2:0] u);
    cal_t     nxt;
    reading_t r;
    bit       ok;
    nxt   = shadow_date;
    r.err = 1'b0;
    case (cmd)
      CMD_UP, CMD_DOWN: begin
        if (cmd == CMD_UP) ok = tick_forward(nxt, u);
        else ok = tick_back(nxt, u);
        if (ok) shadow_date = nxt;
        else r.err = 1'b1;
      end
      CMD_LOAD: begin
        r.err       = take_presets(nxt);
        shadow_date = nxt;
      end
      default: ;
    endcase
    r.date = shadow_date;
    return r;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit calm, input int unsigned long_max);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, long_max);
  endfunction

  // presets near the calendar's edges, now and then out of range
  function automatic cal_t random_presets();
    cal_t p;
    case ($urandom_range(0, 9))
      0:       p.year = 14'd1000;
      1:       p.year = 14'd1001;
      2:       p.year = 14'd9998;
      3:       p.year = 14'd9999;
      4:       p.year = 14'd1900;
      5:       p.year = 14'd2000;
      6:       p.year = 14'd2024;
      7:       p.year = 14'd2100;
      8:       p.year = 14'd2400;
      default: p.year = 14'($urandom_range(1000, 9999));
    endcase
    p.month  = 4'($urandom_range(1, 12));
    p.day    = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(28, 31))
                                           : 5'($urandom_range(1, 31));
    p.hour   = ($urandom_range(0, 2) == 0) ? HOUR_MAX : 5'($urandom_range(0, 23));
    p.minute = ($urandom_range(0, 2) == 0) ? MINSEC_MAX : 6'($urandom_range(0, 59));
    p.second = ($urandom_range(0, 2) == 0) ? MINSEC_MAX : 6'($urandom_range(0, 59));
    if ($urandom_range(0, 99) < 8)
      p.year = ($urandom_range(0, 1) != 0) ? 14'($urandom_range(0, 999))
                                           : 14'($urandom_range(10000, 16383));
    if ($urandom_range(0, 99) < 8)
      p.month = ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(13, 15));
    if ($urandom_range(0, 99) < 8) p.day = 5'd0;
    if ($urandom_range(0, 99) < 8) p.hour = 5'($urandom_range(24, 31));
    if ($urandom_range(0, 99) < 8) p.minute = 6'($urandom_range(60, 63));
    if ($urandom_range(0, 99) < 8) p.second = 6'($urandom_range(60, 63));
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration and stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_PRESET_YEAR:   load_regs.year   = val;
      REG_PRESET_MONTH:  load_regs.month  = val[3:0];
      REG_PRESET_DAY:    load_regs.day    = val[4:0];
      REG_PRESET_HOUR:   load_regs.hour   = val[4:0];
      REG_PRESET_MINUTE: load_regs.minute = val[5:0];
      REG_PRESET_SECOND: load_regs.second = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_presets(input cal_t p);
    write_reg(REG_PRESET_YEAR, p.year);
    write_reg(REG_PRESET_MONTH, CFG_DATA_W'(p.month));
    write_reg(REG_PRESET_DAY, CFG_DATA_W'(p.day));
    write_reg(REG_PRESET_HOUR, CFG_DATA_W'(p.hour));
    write_reg(REG_PRESET_MINUTE, CFG_DATA_W'(p.minute));
    write_reg(REG_PRESET_SECOND, CFG_DATA_W'(p.second));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic queue_order(input logic [1:0] cmd, input logic [2:0] u);
    pending_orders.push_back('{cmd: cmd, unit: u});
  endtask

  // sender pause: hold off until every queued beat is out and checked
  task automatic wait_idle();
    while (pending_orders.size() != 0 || in_valid_i || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------
  int unsigned send_gap    = 0;
  bit          sender_calm = 1'b0;
  order_t      next_order;
  reading_t    fresh;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      command_i  <= CMD_UP;
      unit_i     <= UNIT_SEC;
      send_gap   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        fresh = apply_command(command_i, unit_i);
        expected_readings.push_back(fresh);
        if (command_i == CMD_LOAD) n_loads++;
        else if (command_i != CMD_SPARE) n_steps++;
        if (fresh.err) n_flagged++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0 || pending_orders.size() == 0) begin
          in_valid_i <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          next_order = pending_orders.pop_front();
          in_valid_i <= 1'b1;
          command_i  <= next_order.cmd;
          unit_i     <= next_order.unit;
          if ($urandom_range(0, 99) < 3) sender_calm = !sender_calm;
          send_gap = pick_gap(sender_calm, 40);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver stalls
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  bit          recv_calm  = 1'b0;
  cal_t        got;
  reading_t    want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {year_out_o, month_out_o, day_out_o, hour_out_o, minute_out_o, second_out_o};
        results_seen++;
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing expected: %0d-%0d-%0d %0d:%0d:%0d err %0b",
                     $realtime, got.year, got.month, got.day, got.hour, got.minute,
                     got.second, error_flag_o);
        end else begin
          want = expected_readings.pop_front();
          if (got.year !== want.date.year || got.month !== want.date.month ||
              got.day !== want.date.day || got.hour !== want.date.hour ||
              got.minute !== want.date.minute || got.second !== want.date.second ||
              error_flag_o !== want.err) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: beat %0d expected %0d-%0d-%0d %0d:%0d:%0d err %0b, got %0d-%0d-%0d %0d:%0d:%0d err %0b",
                       $realtime, results_seen, want.date.year, want.date.month,
                       want.date.day, want.date.hour, want.date.minute, want.date.second,
                       want.err, got.year, got.month, got.day, got.hour, got.minute,
                       got.second, error_flag_o);
          end
        end
        // long back-pressure so the block fills and stalls its input
        if (results_seen == 400 || results_seen == 1300) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < 3) recv_calm = !recv_calm;
        stall_left = pick_gap(recv_calm, 30);
      end
    end
  end

  // watchdog: too long without any beat moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("calendar_up_down_counter regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  cal_t        phase_presets;
  logic [1:0]  fav_cmd;
  logic [1:0]  other_cmd;
  int unsigned roll;

  initial begin
    shadow_date = CAL_RESET;
    load_regs   = CAL_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // power-on date: a plain step, then a reload of the reset presets
    queue_order(CMD_UP, UNIT_SEC);
    queue_order(CMD_LOAD, UNIT_SEC);
    wait_idle();

    // top of the year range: every carry into the year is refused; spare codes
    set_presets('{year: 14'd9999, month: 4'd12, day: 5'd31, hour: 5'd23, minute: 6'd59,
                  second: 6'd59});
    queue_order(CMD_LOAD, UNIT_YEAR);
    queue_order(CMD_UP, UNIT_SEC);
    queue_order(CMD_UP, UNIT_MIN);
    queue_order(CMD_UP, UNIT_DAY);
    queue_order(CMD_UP, UNIT_MONTH);
    queue_order(CMD_UP, UNIT_YEAR);
    queue_order(CMD_DOWN, UNIT_SEC);
    queue_order(CMD_SPARE, UNIT_SEC);
    queue_order(CMD_UP, UNIT_SPARE_HI);
    queue_order(CMD_DOWN, UNIT_SPARE_LO);
    wait_idle();

    // bottom of the year range: every borrow out of the year is refused
    set_presets('{year: 14'd1000, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0,
                  second: 6'd0});
    queue_order(CMD_LOAD, UNIT_SEC);
    queue_order(CMD_DOWN, UNIT_SEC);
    queue_order(CMD_DOWN, UNIT_HOUR);
    queue_order(CMD_DOWN, UNIT_DAY);
    queue_order(CMD_DOWN, UNIT_MONTH);
    queue_order(CMD_DOWN, UNIT_YEAR);
    queue_order(CMD_UP, UNIT_HOUR);
    wait_idle();

    // day clamped to Feb 29 in a leap year, then to Feb 28 a year on
    set_presets('{year: 14'd2024, month: 4'd1, day: 5'd31, hour: 5'd12, minute: 6'd30,
                  second: 6'd30});
    queue_order(CMD_LOAD, UNIT_SEC);
    queue_order(CMD_UP, UNIT_MONTH);
    queue_order(CMD_UP, UNIT_YEAR);
    wait_idle();

    // load with every preset out of range, all bits of the year set
    set_presets('{year: 14'h3FFF, month: 4'd0, day: 5'd0, hour: 5'd31, minute: 6'd63,
                  second: 6'd63});
    queue_order(CMD_LOAD, UNIT_SEC);
    wait_idle();

    // random phases: boundary presets, biased walks, loads and noise
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      phase_presets = random_presets();
      set_presets(phase_presets);
      queue_order(CMD_LOAD, 3'($urandom_range(0, 7)));
      fav_cmd   = ($urandom_range(0, 1) != 0) ? CMD_UP : CMD_DOWN;
      other_cmd = (fav_cmd == CMD_UP) ? CMD_DOWN : CMD_UP;
      for (int unsigned k = 1; k < PHASE_LEN; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 82)
          queue_order(($urandom_range(0, 99) < 75) ? fav_cmd : other_cmd,
                      3'($urandom_range(0, 5)));
        else if (roll < 90)
          queue_order(CMD_LOAD, 3'($urandom_range(0, 7)));
        else
          queue_order(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("Ran %0d steps and %0d preset loads across %0d preset settings; %0d refused or flagged.",
             n_steps, n_loads, n_settings, n_flagged);
    $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && expected_readings.size() == 0)
      $display("calendar_up_down_counter regression: pass");
    else
      $display("calendar_up_down_counter regression: fail");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/cudc_pkg.sv
hw/rtl/cudc_next.sv
hw/rtl/calendar_up_down_counter.sv
tb/sv/calendar_up_down_counter_tb.sv
